>>> hw/rtl/env_line_parser_unit_defines.svh
// Assertion helpers for the RTL.
`ifndef ENV_LINE_PARSER_UNIT_DEFINES_SVH
`define ENV_LINE_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define ENVLP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ENVLP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/envlp_pkg.sv
package envlp_pkg;

  localparam int unsigned LINE_COUNT_WIDTH = 16;
  localparam int unsigned LINE_NUM_W       = 16;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned KIND_W           = 3;
  localparam int unsigned STATUS_W         = 2;
  // m tdata: line_number, status, zero pad to whole bytes
  localparam int unsigned M_TDATA_W        = ((LINE_NUM_W + STATUS_W + 7) / 8) * 8;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

  typedef enum logic [6:0] {
    PH_LINE_START = 7'b0000001,
    PH_COMMENT    = 7'b0000010,
    PH_AFTER_CR   = 7'b0000100,
    PH_NAME       = 7'b0001000,
    PH_VALUE_1ST  = 7'b0010000,
    PH_VALUE      = 7'b0100000,
    PH_ERROR      = 7'b1000000
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SKIP  = 3'd0,
    KIND_NAME  = 3'd1,
    KIND_SEP   = 3'd2,
    KIND_VALUE = 3'd3,
    KIND_END   = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_SEP  = 2'd1,
    STATUS_NO_VAL  = 2'd2
  } status_e;

  // Per-byte decision from the classifier
  typedef struct packed {
    phase_e  phase_nxt;
    status_e status;    // includes an error raised by this byte
    kind_e   kind;
    logic    fin;       // terminating zero: state returns to reset
    logic    inc_rep;   // reported line is the incremented count
    logic    inc_nxt;   // stored count advances
  } cls_t;

endpackage

>>> hw/rtl/envlp_classify.sv
module envlp_classify (
  input  envlp_pkg::phase_e              phase_i,
  input  envlp_pkg::status_e             status_i,
  input  logic [envlp_pkg::BYTE_W-1:0]   byte_i,
  output envlp_pkg::cls_t                cls_o
);

  envlp_pkg::phase_e ph;
  logic              is_blank;
  logic              is_eol;

  assign is_blank = (byte_i == envlp_pkg::CH_SPACE) || (byte_i == envlp_pkg::CH_TAB);
  assign is_eol   = (byte_i == envlp_pkg::CH_CR) || (byte_i == envlp_pkg::CH_LF);

  always_comb begin
    ph              = phase_i;
    cls_o.phase_nxt = phase_i;
    cls_o.status    = status_i;
    cls_o.kind      = envlp_pkg::KIND_SKIP;
    cls_o.fin       = 1'b0;
    cls_o.inc_rep   = 1'b0;
    cls_o.inc_nxt   = 1'b0;

    if (phase_i == envlp_pkg::PH_AFTER_CR && byte_i == envlp_pkg::CH_LF) begin
      // LF of a CR LF pair still belongs to the old line
      cls_o.inc_nxt   = 1'b1;
      cls_o.phase_nxt = envlp_pkg::PH_LINE_START;
    end else begin
      if (phase_i == envlp_pkg::PH_AFTER_CR) begin
        cls_o.inc_rep = 1'b1;
        cls_o.inc_nxt = 1'b1;
        ph            = envlp_pkg::PH_LINE_START;
      end

      if (byte_i == envlp_pkg::CH_NUL) begin
        cls_o.fin       = 1'b1;
        cls_o.phase_nxt = envlp_pkg::PH_LINE_START;
        if (ph == envlp_pkg::PH_NAME) begin
          cls_o.status = envlp_pkg::STATUS_NO_SEP;
        end else if (ph == envlp_pkg::PH_VALUE_1ST) begin
          cls_o.status = envlp_pkg::STATUS_NO_VAL;
        end else if (ph == envlp_pkg::PH_VALUE) begin
          cls_o.kind = envlp_pkg::KIND_END;
        end
      end else begin
        cls_o.phase_nxt = ph;
        unique case (ph)
          envlp_pkg::PH_COMMENT: begin
            if (byte_i == envlp_pkg::CH_CR) begin
              cls_o.phase_nxt = envlp_pkg::PH_AFTER_CR;
            end else if (byte_i == envlp_pkg::CH_LF) begin
              cls_o.inc_nxt   = 1'b1;
              cls_o.phase_nxt = envlp_pkg::PH_LINE_START;
            end
          end
          envlp_pkg::PH_NAME: begin
            if (is_blank) begin
              cls_o.kind      = envlp_pkg::KIND_SEP;
              cls_o.phase_nxt = envlp_pkg::PH_VALUE_1ST;
            end else if (is_eol) begin
              cls_o.status    = envlp_pkg::STATUS_NO_SEP;
              cls_o.phase_nxt = envlp_pkg::PH_ERROR;
            end else begin
              cls_o.kind = envlp_pkg::KIND_NAME;
            end
          end
          envlp_pkg::PH_VALUE_1ST: begin
            if (is_eol) begin
              cls_o.status    = envlp_pkg::STATUS_NO_VAL;
              cls_o.phase_nxt = envlp_pkg::PH_ERROR;
            end else begin
              cls_o.kind      = envlp_pkg::KIND_VALUE;
              cls_o.phase_nxt = envlp_pkg::PH_VALUE;
            end
          end
          envlp_pkg::PH_VALUE: begin
            if (byte_i == envlp_pkg::CH_CR) begin
              cls_o.kind      = envlp_pkg::KIND_END;
              cls_o.phase_nxt = envlp_pkg::PH_AFTER_CR;
            end else if (byte_i == envlp_pkg::CH_LF) begin
              cls_o.kind      = envlp_pkg::KIND_END;
              cls_o.inc_nxt   = 1'b1;
              cls_o.phase_nxt = envlp_pkg::PH_LINE_START;
            end else begin
              cls_o.kind = envlp_pkg::KIND_VALUE;
            end
          end
          envlp_pkg::PH_ERROR: begin
            cls_o.phase_nxt = envlp_pkg::PH_ERROR;
          end
          default: begin
            // line start, and any illegal phase code
            if (byte_i == envlp_pkg::CH_HASH) begin
              cls_o.phase_nxt = envlp_pkg::PH_COMMENT;
            end else if (byte_i == envlp_pkg::CH_CR) begin
              cls_o.phase_nxt = envlp_pkg::PH_AFTER_CR;
            end else if (byte_i == envlp_pkg::CH_LF) begin
              cls_o.inc_nxt   = 1'b1;
              cls_o.phase_nxt = envlp_pkg::PH_LINE_START;
            end else if (is_blank) begin
              cls_o.kind      = envlp_pkg::KIND_SEP;
              cls_o.phase_nxt = envlp_pkg::PH_VALUE_1ST;
            end else begin
              cls_o.kind      = envlp_pkg::KIND_NAME;
              cls_o.phase_nxt = envlp_pkg::PH_NAME;
            end
          end
        endcase
      end
    end
  end

endmodule

>>> hw/rtl/env_line_parser_unit.sv
// Byte-stream classifier for name/value environment text. One text byte per
// transaction on s_axis; each byte gives exactly one result on m_axis with its
// kind in tuser, the line number and sticky status in tdata, and tlast set on
// the terminating zero byte, which also returns the parser to its reset state.
// Throughput is one byte per clock while the output is not stalled: the byte is
// registered, classified combinationally against the parse state and written
// to the result register, and back-pressure stalls both stages together. The line count
// is LINE_COUNT_WIDTH bits and saturates; the reported number stops at 65535.
`include "env_line_parser_unit_defines.svh"

module env_line_parser_unit #(
  parameter int unsigned LINE_COUNT_WIDTH = envlp_pkg::LINE_COUNT_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [envlp_pkg::BYTE_W-1:0]     s_axis_tdata,   // [7:0] text_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [envlp_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // [15:0] line_number,
                                                           // [17:16] status, rest 0
  output logic [envlp_pkg::KIND_W-1:0]     m_axis_tuser,   // [2:0] kind
  output logic                             m_axis_tlast    // finished
);

  localparam int unsigned NumW = envlp_pkg::LINE_NUM_W;
  localparam int unsigned PadW = envlp_pkg::M_TDATA_W - NumW - envlp_pkg::STATUS_W;

  // input stage
  logic                          in_valid_q;
  logic [envlp_pkg::BYTE_W-1:0]  in_byte_q;

  // parse state
  envlp_pkg::phase_e             phase_q, phase_d;
  logic [LINE_COUNT_WIDTH-1:0]   count_q, count_d;
  envlp_pkg::status_e            status_q, status_d;

  // result register
  logic                          out_valid_q;
  logic [NumW-1:0]               out_line_q;
  envlp_pkg::status_e            out_status_q;
  envlp_pkg::kind_e              out_kind_q;
  logic                          out_fin_q;

  envlp_pkg::cls_t               cls;
  logic                          out_free;
  logic                          load;
  logic [LINE_COUNT_WIDTH-1:0]   count_inc;
  logic [LINE_COUNT_WIDTH-1:0]   count_rep;
  logic [NumW-1:0]               line_rep;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_free;
  assign load          = in_valid_q && out_free;

  envlp_classify u_classify (
    .phase_i  (phase_q),
    .status_i (status_q),
    .byte_i   (in_byte_q),
    .cls_o    (cls)
  );

  assign count_inc = (count_q == {LINE_COUNT_WIDTH{1'b1}}) ? count_q
                                                           : count_q + 1'b1;
  assign count_rep = cls.inc_rep ? count_inc : count_q;

  generate
    if (LINE_COUNT_WIDTH > NumW) begin : g_sat
      assign line_rep = (|count_rep[LINE_COUNT_WIDTH-1:NumW]) ? {NumW{1'b1}}
                                                              : count_rep[NumW-1:0];
    end else begin : g_ext
      assign line_rep = NumW'(count_rep);
    end
  endgenerate

  always_comb begin
    phase_d  = cls.phase_nxt;
    status_d = cls.fin ? envlp_pkg::STATUS_OK : cls.status;
    if (cls.fin) begin
      count_d = LINE_COUNT_WIDTH'(1);
    end else if (cls.inc_nxt) begin
      count_d = count_inc;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= envlp_pkg::PH_LINE_START;
      count_q     <= LINE_COUNT_WIDTH'(1);
      status_q    <= envlp_pkg::STATUS_OK;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (load) begin
        phase_q  <= phase_d;
        count_q  <= count_d;
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (load) begin
      out_line_q   <= line_rep;
      out_status_q <= cls.status;
      out_kind_q   <= cls.kind;
      out_fin_q    <= cls.fin;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_status_q, out_line_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_fin_q;

  `ENVLP_ASSERT_IMPL(a_err_parks, clk_i, rst_ni, status_q != envlp_pkg::STATUS_OK, phase_q == envlp_pkg::PH_ERROR, "stored error outside error phase")
  `ENVLP_ASSERT_IMPL(a_err_skips, clk_i, rst_ni, out_valid_q && out_status_q != envlp_pkg::STATUS_OK, out_kind_q == envlp_pkg::KIND_SKIP, "byte classified while in error")
  `ENVLP_ASSERT_IMPL(a_fin_kind, clk_i, rst_ni, out_valid_q && out_fin_q, out_kind_q == envlp_pkg::KIND_SKIP || out_kind_q == envlp_pkg::KIND_END, "bad kind on buffer end")
  `ENVLP_ASSERT_NEXT(a_fin_reset, clk_i, rst_ni, load && cls.fin, phase_q == envlp_pkg::PH_LINE_START && count_q == LINE_COUNT_WIDTH'(1) && status_q == envlp_pkg::STATUS_OK, "state not reset after buffer end")

endmodule

>>> test/env_line_parser_unit_test.sv
// Keeps the parse state of the text seen so far and queues the class of
// every accepted byte until its result comes back.
class byte_class_tracker;
  typedef struct {
    envlp_pkg::kind_e   kind;
    logic [15:0]        line_no;
    envlp_pkg::status_e status;
    logic               fin;
  } byte_class_t;

  envlp_pkg::phase_e  phase;
  longint unsigned    line_cnt;
  envlp_pkg::status_e err;
  byte_class_t        pending_class[$];
  int                 mismatches;

  function new();
    mismatches = 0;
    clear_state();
  endfunction

  function void clear_state();
    phase    = envlp_pkg::PH_LINE_START;
    line_cnt = 1;
    err      = envlp_pkg::STATUS_OK;
  endfunction

  function void bump_line();
    if (line_cnt < (64'd1 << envlp_pkg::LINE_COUNT_WIDTH) - 1) begin
      line_cnt++;
    end
  endfunction

  function logic [15:0] shown_line();
    return (line_cnt > 64'hFFFF) ? 16'hFFFF : line_cnt[15:0];
  endfunction

  function void note_byte(logic [7:0] c);
    envlp_pkg::phase_e ph;
    byte_class_t       e;
    ph        = phase;
    e.kind    = envlp_pkg::KIND_SKIP;
    e.fin     = 1'b0;
    // LF after CR belongs to the old line; anything else opens the next one
    if (ph == envlp_pkg::PH_AFTER_CR) begin
      if (c == envlp_pkg::CH_LF) begin
        e.line_no = shown_line();
        e.status  = err;
        bump_line();
        phase = envlp_pkg::PH_LINE_START;
        pending_class.push_back(e);
        return;
      end
      bump_line();
      ph = envlp_pkg::PH_LINE_START;
    end
    e.line_no = shown_line();
    if (c == envlp_pkg::CH_NUL) begin
      e.fin = 1'b1;
      if (ph == envlp_pkg::PH_NAME) begin
        err = envlp_pkg::STATUS_NO_SEP;
      end else if (ph == envlp_pkg::PH_VALUE_1ST) begin
        err = envlp_pkg::STATUS_NO_VAL;
      end else if (ph == envlp_pkg::PH_VALUE) begin
        e.kind = envlp_pkg::KIND_END;
      end
    end else begin
      case (ph)
        envlp_pkg::PH_COMMENT: begin
          if (c == envlp_pkg::CH_CR) begin
            ph = envlp_pkg::PH_AFTER_CR;
          end else if (c == envlp_pkg::CH_LF) begin
            bump_line();
            ph = envlp_pkg::PH_LINE_START;
          end
        end
        envlp_pkg::PH_NAME: begin
          if (c == envlp_pkg::CH_SPACE || c == envlp_pkg::CH_TAB) begin
            e.kind = envlp_pkg::KIND_SEP;
            ph     = envlp_pkg::PH_VALUE_1ST;
          end else if (c == envlp_pkg::CH_CR || c == envlp_pkg::CH_LF) begin
            err = envlp_pkg::STATUS_NO_SEP;
            ph  = envlp_pkg::PH_ERROR;
          end else begin
            e.kind = envlp_pkg::KIND_NAME;
          end
        end
        envlp_pkg::PH_VALUE_1ST, envlp_pkg::PH_VALUE: begin
          if (c == envlp_pkg::CH_CR || c == envlp_pkg::CH_LF) begin
            if (ph == envlp_pkg::PH_VALUE_1ST) begin
              err = envlp_pkg::STATUS_NO_VAL;
              ph  = envlp_pkg::PH_ERROR;
            end else begin
              e.kind = envlp_pkg::KIND_END;
              if (c == envlp_pkg::CH_CR) begin
                ph = envlp_pkg::PH_AFTER_CR;
              end else begin
                bump_line();
                ph = envlp_pkg::PH_LINE_START;
              end
            end
          end else begin
            e.kind = envlp_pkg::KIND_VALUE;
            ph     = envlp_pkg::PH_VALUE;
          end
        end
        envlp_pkg::PH_ERROR: begin
        end
        default: begin
          if (c == envlp_pkg::CH_HASH) begin
            ph = envlp_pkg::PH_COMMENT;
          end else if (c == envlp_pkg::CH_CR) begin
            ph = envlp_pkg::PH_AFTER_CR;
          end else if (c == envlp_pkg::CH_LF) begin
            bump_line();
            ph = envlp_pkg::PH_LINE_START;
          end else if (c == envlp_pkg::CH_SPACE || c == envlp_pkg::CH_TAB) begin
            e.kind = envlp_pkg::KIND_SEP;
            ph     = envlp_pkg::PH_VALUE_1ST;
          end else begin
            e.kind = envlp_pkg::KIND_NAME;
            ph     = envlp_pkg::PH_NAME;
          end
        end
      endcase
    end
    e.status = err;
    pending_class.push_back(e);
    if (e.fin) begin
      clear_state();
    end else begin
      phase = ph;
    end
  endfunction

  function void check_result(logic [envlp_pkg::M_TDATA_W-1:0] tdata,
                             logic [envlp_pkg::KIND_W-1:0] tuser, logic tlast);
    byte_class_t e;
    if (pending_class.size() == 0) begin
      $error("result with no byte pending: tdata %h, tuser %0d, tlast %0b",
             tdata, tuser, tlast);
      mismatches++;
      return;
    end
    e = pending_class.pop_front();
    if (tuser !== e.kind) begin
      $error("kind: expected %0d, actual %0d", e.kind, tuser);
      mismatches++;
    end
    if (tdata[15:0] !== e.line_no) begin
      $error("line_number: expected %0d, actual %0d", e.line_no, tdata[15:0]);
      mismatches++;
    end
    if (tdata[17:16] !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, tdata[17:16]);
      mismatches++;
    end
    if (tlast !== e.fin) begin
      $error("finished: expected %0b, actual %0b", e.fin, tlast);
      mismatches++;
    end
    if ((tdata >> 18) !== '0) begin
      $error("tdata padding: expected 0, actual %h", tdata >> 18);
      mismatches++;
    end
  endfunction
endclass

module env_line_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_BYTES = 1900;

  // comment, empty lines, CR LF, CR then a new line, leading blank, buffer
  // ends in name, after separator and in value, both errors with ignored bytes
  localparam logic [7:0] DIRECTED [29] = '{
    envlp_pkg::CH_LF, envlp_pkg::CH_HASH, envlp_pkg::CH_LF,
    envlp_pkg::CH_CR, envlp_pkg::CH_LF,
    8'hFF, envlp_pkg::CH_SPACE, 8'h01, envlp_pkg::CH_CR,
    envlp_pkg::CH_TAB, 8'h80, envlp_pkg::CH_LF,
    8'h7F, envlp_pkg::CH_NUL,
    8'h61, envlp_pkg::CH_SPACE, envlp_pkg::CH_NUL,
    8'h62, envlp_pkg::CH_CR, 8'h7A, envlp_pkg::CH_NUL,
    8'h63, envlp_pkg::CH_SPACE, envlp_pkg::CH_SPACE, envlp_pkg::CH_NUL,
    8'h64, envlp_pkg::CH_SPACE, envlp_pkg::CH_LF, envlp_pkg::CH_NUL
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [envlp_pkg::BYTE_W-1:0]    s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [envlp_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic [envlp_pkg::KIND_W-1:0]    m_axis_tuser;
  logic                            m_axis_tlast;

  byte_class_tracker sb = new();
  int                send_idle_max = 8;
  int                recv_idle_max = 8;
  int                recv_hold     = 0;
  int                cycle_cnt     = 0;
  logic [7:0]        text_q[$];

  env_line_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b);
  endtask

  // drop tvalid so the last byte is not taken again, then drain
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_class.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] text_char(bit blanks);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == envlp_pkg::CH_CR || c == envlp_pkg::CH_LF ||
           (!blanks && (c == envlp_pkg::CH_SPACE || c == envlp_pkg::CH_TAB)));
    return c;
  endfunction

  function automatic void push_name();
    logic [7:0] c;
    do c = text_char(1'b0); while (c == envlp_pkg::CH_HASH);
    text_q.push_back(c);
    repeat ($urandom_range(0, 5)) text_q.push_back(text_char(1'b0));
  endfunction

  function automatic void push_blank();
    text_q.push_back($urandom_range(0, 1) ? envlp_pkg::CH_SPACE : envlp_pkg::CH_TAB);
  endfunction

  // One buffer: mostly well-formed lines, some comments, empty lines,
  // malformed lines and raw noise, closed by the terminating zero.
  function automatic void build_buffer();
    int sel;
    int ending;
    text_q.delete();
    repeat ($urandom_range(1, 8)) begin
      sel = $urandom_range(0, 19);
      if (sel < 11) begin
        if (sel != 10) push_name();
        push_blank();
        repeat ($urandom_range(1, 8)) text_q.push_back(text_char(1'b1));
      end else if (sel < 13) begin
        text_q.push_back(envlp_pkg::CH_HASH);
        repeat ($urandom_range(0, 6)) text_q.push_back(text_char(1'b1));
      end else if (sel == 15) begin
        push_name();
      end else if (sel == 16) begin
        push_name();
        push_blank();
      end else if (sel > 16) begin
        repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(1, 255)));
      end
      ending = $urandom_range(0, 2);
      if (ending == 0) begin
        text_q.push_back(envlp_pkg::CH_LF);
      end else begin
        text_q.push_back(envlp_pkg::CH_CR);
        if (ending == 2) text_q.push_back(envlp_pkg::CH_LF);
      end
    end
    // cut some buffers short so the zero lands mid-line
    if ($urandom_range(0, 5) == 0 && text_q.size() > 3) begin
      repeat ($urandom_range(1, 3)) void'(text_q.pop_back());
    end
    text_q.push_back(envlp_pkg::CH_NUL);
  endfunction

  initial begin : result_side
    int gap;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (recv_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (recv_hold) @(negedge clk_i);
        recv_hold = 0;
      end
      gap = $urandom_range(0, recv_idle_max);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  initial begin : text_side
    int sent;
    int buffers;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
    settle();

    sent    = 0;
    buffers = 0;
    while (sent < RANDOM_BYTES) begin
      send_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      recv_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      if (buffers == 4) recv_hold = 300;
      build_buffer();
      foreach (text_q[i]) send_byte(text_q[i]);
      sent += text_q.size();
      buffers++;
      if (buffers % 10 == 0) settle();
    end
    settle();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_class.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/envlp_pkg.sv
hw/rtl/envlp_classify.sv
hw/rtl/env_line_parser_unit.sv
test/env_line_parser_unit_test.sv
